[hdl/lscf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscf_pkg: shared types, constants and solver program
// Widths of the power sums, the queued sum set, the wide-integer opcodes and
// the fixed solver program run by the back end.
// ----------------------------------------------------------------------------
package lscf_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int CNT_W           = 13;
  localparam int S1_W            = 28;
  localparam int S2_W            = 44;
  localparam int S3_W            = 60;
  localparam int MAX_POINTS_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int MIN_POINTS      = 3;

  localparam int IN_W    = 32;
  localparam int OUT_W   = 176;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int LIMBS   = 12;
  localparam int W       = 32 * LIMBS;
  localparam int RF_DEPTH = 32;
  localparam int RF_AW   = $clog2(RF_DEPTH);
  localparam int PC_W    = 7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_SING = 2'd2;
  localparam logic [1:0] ST_NEG  = 2'd3;

  localparam logic [RF_AW-1:0] R_N    = 5'd0;
  localparam logic [RF_AW-1:0] R_SX   = 5'd1;
  localparam logic [RF_AW-1:0] R_SY   = 5'd2;
  localparam logic [RF_AW-1:0] R_SXX  = 5'd3;
  localparam logic [RF_AW-1:0] R_SYY  = 5'd4;
  localparam logic [RF_AW-1:0] R_SXY  = 5'd5;
  localparam logic [RF_AW-1:0] R_SXXX = 5'd6;
  localparam logic [RF_AW-1:0] R_SYYY = 5'd7;
  localparam logic [RF_AW-1:0] R_SXYY = 5'd8;
  localparam logic [RF_AW-1:0] R_SXXY = 5'd9;
  localparam logic [RF_AW-1:0] R_TSQ  = 5'd10;
  localparam logic [RF_AW-1:0] R_C    = 5'd11;
  localparam logic [RF_AW-1:0] R_D    = 5'd12;
  localparam logic [RF_AW-1:0] R_G    = 5'd13;
  localparam logic [RF_AW-1:0] R_E    = 5'd14;
  localparam logic [RF_AW-1:0] R_H    = 5'd15;
  localparam logic [RF_AW-1:0] R_DEN  = 5'd16;
  localparam logic [RF_AW-1:0] R_NX   = 5'd17;
  localparam logic [RF_AW-1:0] R_NY   = 5'd18;
  localparam logic [RF_AW-1:0] R_DD   = 5'd19;
  localparam logic [RF_AW-1:0] R_RAD  = 5'd20;
  localparam logic [RF_AW-1:0] R_Q    = 5'd21;
  localparam logic [RF_AW-1:0] R_T0   = 5'd22;
  localparam logic [RF_AW-1:0] R_T1   = 5'd23;
  localparam logic [RF_AW-1:0] R_T2   = 5'd24;
  localparam logic [RF_AW-1:0] R_CX   = 5'd25;
  localparam logic [RF_AW-1:0] R_CY   = 5'd26;
  localparam logic [RF_AW-1:0] R_RB   = 5'd27;
  localparam logic [RF_AW-1:0] R_ERR  = 5'd28;

  typedef struct packed {
    logic        [CNT_W-1:0] count;
    logic signed [S1_W-1:0]  sum_x;
    logic signed [S1_W-1:0]  sum_y;
    logic signed [S2_W-1:0]  sum_xx;
    logic signed [S2_W-1:0]  sum_yy;
    logic signed [S2_W-1:0]  sum_xy;
    logic signed [S3_W-1:0]  sum_xxx;
    logic signed [S3_W-1:0]  sum_yyy;
    logic signed [S3_W-1:0]  sum_xyy;
    logic signed [S3_W-1:0]  sum_xxy;
  } acc_set_t;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_SHL, OP_ABS, OP_DIV, OP_SQRT,
    OP_SGN32, OP_RQ, OP_CLAMP64, OP_CHKPOS, OP_CHKNN, OP_END
  } op_t;

  typedef enum logic [2:0] {
    SH_NONE, SH_1, SH_2, SH_F, SH_F1, SH_2F, SH_2F2
  } shift_t;

  typedef struct packed {
    op_t              op;
    logic [RF_AW-1:0] dst;
    logic [RF_AW-1:0] a;
    logic [RF_AW-1:0] b;
    shift_t           sh;
  } instr_t;

  function automatic instr_t mk(op_t op, logic [RF_AW-1:0] d, logic [RF_AW-1:0] a,
                                logic [RF_AW-1:0] b, shift_t sh);
    instr_t r;
    r.op  = op;
    r.dst = d;
    r.a   = a;
    r.b   = b;
    r.sh  = sh;
    return r;
  endfunction

  function automatic instr_t prog(logic [PC_W-1:0] pc);
    instr_t i;
    unique case (pc)
      7'd0:  i = mk(OP_ADD, R_TSQ, R_SXX, R_SYY, SH_NONE);
      7'd1:  i = mk(OP_MUL, R_T0, R_N, R_SXX, SH_NONE);
      7'd2:  i = mk(OP_MUL, R_T1, R_SX, R_SX, SH_NONE);
      7'd3:  i = mk(OP_SUB, R_C, R_T0, R_T1, SH_NONE);
      7'd4:  i = mk(OP_MUL, R_T0, R_N, R_SXY, SH_NONE);
      7'd5:  i = mk(OP_MUL, R_T1, R_SX, R_SY, SH_NONE);
      7'd6:  i = mk(OP_SUB, R_D, R_T0, R_T1, SH_NONE);
      7'd7:  i = mk(OP_MUL, R_T0, R_N, R_SYY, SH_NONE);
      7'd8:  i = mk(OP_MUL, R_T1, R_SY, R_SY, SH_NONE);
      7'd9:  i = mk(OP_SUB, R_G, R_T0, R_T1, SH_NONE);
      7'd10: i = mk(OP_ADD, R_T0, R_SXXX, R_SXYY, SH_NONE);
      7'd11: i = mk(OP_MUL, R_T0, R_N, R_T0, SH_NONE);
      7'd12: i = mk(OP_MUL, R_T1, R_TSQ, R_SX, SH_NONE);
      7'd13: i = mk(OP_SUB, R_E, R_T0, R_T1, SH_NONE);
      7'd14: i = mk(OP_ADD, R_T0, R_SXXY, R_SYYY, SH_NONE);
      7'd15: i = mk(OP_MUL, R_T0, R_N, R_T0, SH_NONE);
      7'd16: i = mk(OP_MUL, R_T1, R_TSQ, R_SY, SH_NONE);
      7'd17: i = mk(OP_SUB, R_H, R_T0, R_T1, SH_NONE);
      7'd18: i = mk(OP_MUL, R_T0, R_C, R_G, SH_NONE);
      7'd19: i = mk(OP_MUL, R_T1, R_D, R_D, SH_NONE);
      7'd20: i = mk(OP_SUB, R_DEN, R_T0, R_T1, SH_NONE);
      7'd21: i = mk(OP_CHKPOS, R_T0, R_DEN, R_DEN, SH_NONE);
      7'd22: i = mk(OP_MUL, R_T0, R_E, R_G, SH_NONE);
      7'd23: i = mk(OP_MUL, R_T1, R_H, R_D, SH_NONE);
      7'd24: i = mk(OP_SUB, R_NX, R_T0, R_T1, SH_NONE);
      7'd25: i = mk(OP_MUL, R_T0, R_H, R_C, SH_NONE);
      7'd26: i = mk(OP_MUL, R_T1, R_E, R_D, SH_NONE);
      7'd27: i = mk(OP_SUB, R_NY, R_T0, R_T1, SH_NONE);
      7'd28: i = mk(OP_MUL, R_DD, R_DEN, R_DEN, SH_NONE);
      7'd29: i = mk(OP_SHL, R_T2, R_DEN, R_DEN, SH_1);
      7'd30: i = mk(OP_ABS, R_T0, R_NX, R_NX, SH_NONE);
      7'd31: i = mk(OP_SHL, R_T0, R_T0, R_T0, SH_F);
      7'd32: i = mk(OP_ADD, R_T0, R_T0, R_DEN, SH_NONE);
      7'd33: i = mk(OP_DIV, R_T0, R_T0, R_T2, SH_NONE);
      7'd34: i = mk(OP_SGN32, R_CX, R_T0, R_NX, SH_NONE);
      7'd35: i = mk(OP_ABS, R_T0, R_NY, R_NY, SH_NONE);
      7'd36: i = mk(OP_SHL, R_T0, R_T0, R_T0, SH_F);
      7'd37: i = mk(OP_ADD, R_T0, R_T0, R_DEN, SH_NONE);
      7'd38: i = mk(OP_DIV, R_T0, R_T0, R_T2, SH_NONE);
      7'd39: i = mk(OP_SGN32, R_CY, R_T0, R_NY, SH_NONE);
      7'd40: i = mk(OP_SHL, R_T0, R_DD, R_DD, SH_2);
      7'd41: i = mk(OP_MUL, R_RAD, R_T0, R_TSQ, SH_NONE);
      7'd42: i = mk(OP_MUL, R_T0, R_NX, R_SX, SH_NONE);
      7'd43: i = mk(OP_MUL, R_T1, R_NY, R_SY, SH_NONE);
      7'd44: i = mk(OP_ADD, R_T0, R_T0, R_T1, SH_NONE);
      7'd45: i = mk(OP_SHL, R_T1, R_DEN, R_DEN, SH_2);
      7'd46: i = mk(OP_MUL, R_T0, R_T1, R_T0, SH_NONE);
      7'd47: i = mk(OP_SUB, R_RAD, R_RAD, R_T0, SH_NONE);
      7'd48: i = mk(OP_MUL, R_T0, R_NX, R_NX, SH_NONE);
      7'd49: i = mk(OP_MUL, R_T1, R_NY, R_NY, SH_NONE);
      7'd50: i = mk(OP_ADD, R_T0, R_T0, R_T1, SH_NONE);
      7'd51: i = mk(OP_MUL, R_T0, R_N, R_T0, SH_NONE);
      7'd52: i = mk(OP_ADD, R_RAD, R_RAD, R_T0, SH_NONE);
      7'd53: i = mk(OP_SHL, R_T0, R_DD, R_DD, SH_2);
      7'd54: i = mk(OP_MUL, R_Q, R_N, R_T0, SH_NONE);
      7'd55: i = mk(OP_CHKNN, R_T0, R_RAD, R_RAD, SH_NONE);
      7'd56: i = mk(OP_SHL, R_T0, R_RAD, R_RAD, SH_2F2);
      7'd57: i = mk(OP_DIV, R_T0, R_T0, R_Q, SH_NONE);
      7'd58: i = mk(OP_SQRT, R_T0, R_T0, R_T0, SH_NONE);
      7'd59: i = mk(OP_RQ, R_RB, R_T0, R_T0, SH_NONE);
      7'd60: i = mk(OP_MUL, R_T0, R_CX, R_SX, SH_NONE);
      7'd61: i = mk(OP_MUL, R_T1, R_CY, R_SY, SH_NONE);
      7'd62: i = mk(OP_ADD, R_T0, R_T0, R_T1, SH_NONE);
      7'd63: i = mk(OP_SHL, R_T0, R_T0, R_T0, SH_F1);
      7'd64: i = mk(OP_SHL, R_T1, R_TSQ, R_TSQ, SH_2F);
      7'd65: i = mk(OP_SUB, R_T1, R_T1, R_T0, SH_NONE);
      7'd66: i = mk(OP_MUL, R_T0, R_CX, R_CX, SH_NONE);
      7'd67: i = mk(OP_MUL, R_T2, R_CY, R_CY, SH_NONE);
      7'd68: i = mk(OP_ADD, R_T0, R_T0, R_T2, SH_NONE);
      7'd69: i = mk(OP_MUL, R_T0, R_N, R_T0, SH_NONE);
      7'd70: i = mk(OP_ADD, R_T1, R_T1, R_T0, SH_NONE);
      7'd71: i = mk(OP_MUL, R_T0, R_RB, R_RB, SH_NONE);
      7'd72: i = mk(OP_MUL, R_T0, R_N, R_T0, SH_NONE);
      7'd73: i = mk(OP_SUB, R_T1, R_T1, R_T0, SH_NONE);
      7'd74: i = mk(OP_CLAMP64, R_ERR, R_T1, R_T1, SH_NONE);
      default: i = mk(OP_END, R_T0, R_T0, R_T0, SH_NONE);
    endcase
    return i;
  endfunction

endpackage

[hdl/lscf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lscf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/lscf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscf_front: point intake and power-sum accumulation
// Two multiply stages form the point powers, a third adds them to the sums
// and hands a closed set to the queue.
// ----------------------------------------------------------------------------
module lscf_front #(
  parameter int SAMPLE_BITS = lscf_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_POINTS  = lscf_pkg::MAX_POINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [lscf_pkg::IN_W-1:0]   s_tdata,
  input  logic                        s_tlast,
  input  logic [lscf_pkg::QCNT_W-1:0] q_count,
  output logic                        push,
  output lscf_pkg::acc_set_t          push_data
);

  localparam int SW = lscf_pkg::SAMPLE_W;
  localparam int SH = SW - SAMPLE_BITS;

  logic [SW-1:0]        xs, ys;
  logic signed [SW-1:0] x_in, y_in;
  logic                 take;

  logic                 v1, last1;
  logic signed [SW-1:0] x1, y1;
  logic signed [31:0]   xx1, yy1, xy1;

  logic                 v2, last2;
  logic signed [31:0]   xx2, yy2, xy2;
  logic signed [SW-1:0] x2, y2;
  logic signed [47:0]   xxx2, yyy2, xyy2, xxy2;

  lscf_pkg::acc_set_t   sums, sums_next;
  logic [lscf_pkg::QCNT_W:0] pending;

  assign xs   = s_tdata[SW-1:0] << SH;
  assign ys   = s_tdata[2*SW-1:SW] << SH;
  assign x_in = $signed(xs) >>> SH;
  assign y_in = $signed(ys) >>> SH;
  assign take = s_tvalid && s_tready;

  assign pending  = (lscf_pkg::QCNT_W+1)'(q_count)
                  + (lscf_pkg::QCNT_W+1)'(v1 && last1)
                  + (lscf_pkg::QCNT_W+1)'(v2 && last2);
  assign s_tready = pending < (lscf_pkg::QCNT_W+1)'(lscf_pkg::QDEPTH);

  always_comb begin
    sums_next = sums;
    if (sums.count < lscf_pkg::CNT_W'(MAX_POINTS)) begin
      sums_next.count   = sums.count + 1'b1;
      sums_next.sum_x   = sums.sum_x + lscf_pkg::S1_W'(x2);
      sums_next.sum_y   = sums.sum_y + lscf_pkg::S1_W'(y2);
      sums_next.sum_xx  = sums.sum_xx + lscf_pkg::S2_W'(xx2);
      sums_next.sum_yy  = sums.sum_yy + lscf_pkg::S2_W'(yy2);
      sums_next.sum_xy  = sums.sum_xy + lscf_pkg::S2_W'(xy2);
      sums_next.sum_xxx = sums.sum_xxx + lscf_pkg::S3_W'(xxx2);
      sums_next.sum_yyy = sums.sum_yyy + lscf_pkg::S3_W'(yyy2);
      sums_next.sum_xyy = sums.sum_xyy + lscf_pkg::S3_W'(xyy2);
      sums_next.sum_xxy = sums.sum_xxy + lscf_pkg::S3_W'(xxy2);
    end
  end

  assign push      = v2 && last2;
  assign push_data = sums_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      sums <= '0;
    end else begin
      v1    <= take;
      last1 <= s_tlast;
      x1    <= x_in;
      y1    <= y_in;
      xx1   <= x_in * x_in;
      yy1   <= y_in * y_in;
      xy1   <= x_in * y_in;

      v2    <= v1;
      last2 <= last1;
      x2    <= x1;
      y2    <= y1;
      xx2   <= xx1;
      yy2   <= yy1;
      xy2   <= xy1;
      xxx2  <= xx1 * x1;
      yyy2  <= yy1 * y1;
      xyy2  <= yy1 * x1;
      xxy2  <= xx1 * y1;

      if (v2) begin
        // clear the sums once the set is handed on
        sums <= last2 ? '0 : sums_next;
      end
    end
  end

endmodule

[hdl/lscf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscf_queue: short queue of closed sum sets
// Lets the accumulator carry on while the solver works on an earlier set.
// ----------------------------------------------------------------------------
module lscf_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  lscf_pkg::acc_set_t          push_data,
  input  logic                        pop,
  output logic                        q_valid,
  output lscf_pkg::acc_set_t          q_data,
  output logic [lscf_pkg::QCNT_W-1:0] count
);

  lscf_pkg::acc_set_t              entries [lscf_pkg::QDEPTH];
  logic [lscf_pkg::QPTR_W-1:0]     wptr, rptr;

  assign q_valid = count != '0;
  assign q_data  = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        entries[wptr] <= push_data;
        wptr          <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + lscf_pkg::QCNT_W'(push) - lscf_pkg::QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < lscf_pkg::QCNT_W'(lscf_pkg::QDEPTH)))
    else $error("set queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("set queue underflow");

endmodule

[hdl/lscf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscf_back: wide-integer solver
// Sequencer over a 384-bit register file: limb-serial multiply, restoring
// divide and square root, combinational add, shift and clamp, result register.
// ----------------------------------------------------------------------------
module lscf_back #(
  parameter int FRAC_BITS = lscf_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  lscf_pkg::acc_set_t         q_data,
  output logic                       q_pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [lscf_pkg::OUT_W-1:0] m_tdata
);

  localparam int W   = lscf_pkg::W;
  localparam int CW  = $clog2(W);
  localparam int LW  = $clog2(lscf_pkg::LIMBS);
  localparam int AW  = lscf_pkg::RF_AW;

  localparam logic [W-1:0] I32_MAX = {{(W-31){1'b0}}, {31{1'b1}}};
  localparam logic [W-1:0] I32_MIN = {{(W-31){1'b1}}, {31{1'b0}}};
  localparam logic [W-1:0] I64_MAX = {{(W-63){1'b0}}, {63{1'b1}}};
  localparam logic [W-1:0] I64_MIN = {{(W-63){1'b1}}, {63{1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_FETCH, S_RDA, S_RDB, S_ALU, S_MUL, S_DIV, S_SQRT, S_WB, S_OUT
  } state_t;

  state_t                   state;
  lscf_pkg::acc_set_t       snap;
  logic [lscf_pkg::PC_W-1:0] pc;
  lscf_pkg::instr_t         ins;
  logic [3:0]               ld_idx;
  logic [W-1:0]             ld_val;

  logic [W-1:0]             opa, opb, acc, alu_res;
  logic [W:0]               rem, rem_next, trial, tst;
  logic                     ge;
  logic [CW-1:0]            cnt;
  logic [LW-1:0]            mi, mj, mk;
  logic                     mph;
  logic [63:0]              prod;
  logic [CW-1:0]            shamt;

  logic                     we;
  logic [AW-1:0]            waddr, raddr;
  logic [W-1:0]             wdata, rdata;

  logic [31:0]              cx_r, cy_r, rq_r;
  logic [63:0]              err_r;
  logic [1:0]               st_r;
  logic [31:0]              o_cx, o_cy, o_rq;
  logic [63:0]              o_err;
  logic [lscf_pkg::CNT_W-1:0] o_cnt;
  logic [1:0]               o_st;

  logic [W-1:0]             sv;
  logic [62:0]              s63;
  logic [63:0]              r64;

  function automatic logic [31:0] limb(logic [W-1:0] v, logic [LW-1:0] k);
    return v[{k, 5'b0} +: 32];
  endfunction

  assign ins = lscf_pkg::prog(pc);

  lscf_ram #(.WIDTH(W), .DEPTH(lscf_pkg::RF_DEPTH)) u_rf (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    unique case (ld_idx)
      4'd0:    ld_val = {{(W-lscf_pkg::CNT_W){1'b0}}, snap.count};
      4'd1:    ld_val = W'(snap.sum_x);
      4'd2:    ld_val = W'(snap.sum_y);
      4'd3:    ld_val = W'(snap.sum_xx);
      4'd4:    ld_val = W'(snap.sum_yy);
      4'd5:    ld_val = W'(snap.sum_xy);
      4'd6:    ld_val = W'(snap.sum_xxx);
      4'd7:    ld_val = W'(snap.sum_yyy);
      4'd8:    ld_val = W'(snap.sum_xyy);
      4'd9:    ld_val = W'(snap.sum_xxy);
      default: ld_val = '0;
    endcase
  end

  assign we    = (state == S_LOAD) || (state == S_WB);
  assign waddr = (state == S_LOAD) ? AW'(ld_idx) : ins.dst;
  assign wdata = (state == S_LOAD) ? ld_val : acc;
  assign raddr = (state == S_RDA) ? ins.b : ins.a;
  assign q_pop = (state == S_IDLE) && q_valid;

  always_comb begin
    unique case (ins.sh)
      lscf_pkg::SH_1:   shamt = CW'(1);
      lscf_pkg::SH_2:   shamt = CW'(2);
      lscf_pkg::SH_F:   shamt = CW'(FRAC_BITS);
      lscf_pkg::SH_F1:  shamt = CW'(FRAC_BITS + 1);
      lscf_pkg::SH_2F:  shamt = CW'(2 * FRAC_BITS);
      lscf_pkg::SH_2F2: shamt = CW'(2 * FRAC_BITS + 2);
      default:          shamt = '0;
    endcase
  end

  always_comb begin
    sv  = opb[W-1] ? (W'(0) - opa) : opa;
    s63 = ($signed(opa) > $signed(I64_MAX)) ? {63{1'b1}} : opa[62:0];
    r64 = ({1'b0, s63} + 64'd1) >> 1;
    unique case (ins.op)
      lscf_pkg::OP_ADD: alu_res = opa + opb;
      lscf_pkg::OP_SUB: alu_res = opa - opb;
      lscf_pkg::OP_SHL: alu_res = opa << shamt;
      lscf_pkg::OP_ABS: alu_res = opa[W-1] ? (W'(0) - opa) : opa;
      lscf_pkg::OP_SGN32: begin
        if ($signed(sv) > $signed(I32_MAX)) alu_res = I32_MAX;
        else if ($signed(sv) < $signed(I32_MIN)) alu_res = I32_MIN;
        else alu_res = sv;
      end
      lscf_pkg::OP_RQ: begin
        alu_res = {{(W-32){1'b0}}, (r64 > 64'hffffffff) ? 32'hffffffff : r64[31:0]};
      end
      lscf_pkg::OP_CLAMP64: begin
        if ($signed(opa) > $signed(I64_MAX)) alu_res = I64_MAX;
        else if ($signed(opa) < $signed(I64_MIN)) alu_res = I64_MIN;
        else alu_res = opa;
      end
      default: alu_res = opa;
    endcase
  end

  // one quotient bit or one root bit a cycle
  always_comb begin
    if (state == S_SQRT) begin
      trial = {rem[W-2:0], opa[W-1:W-2]};
      tst   = {acc[W-2:0], 2'b01};
    end else begin
      trial = {rem[W-1:0], opa[W-1]};
      tst   = {1'b0, opb};
    end
    ge       = trial >= tst;
    rem_next = ge ? (trial - tst) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      pc       <= '0;
      ld_idx   <= '0;
      mph      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            snap  <= q_data;
            cx_r  <= '0;
            cy_r  <= '0;
            rq_r  <= '0;
            err_r <= '0;
            pc    <= '0;
            ld_idx <= '0;
            if (q_data.count < lscf_pkg::CNT_W'(lscf_pkg::MIN_POINTS)) begin
              st_r  <= lscf_pkg::ST_FEW;
              state <= S_OUT;
            end else begin
              st_r  <= lscf_pkg::ST_OK;
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          ld_idx <= ld_idx + 1'b1;
          if (ld_idx == 4'(lscf_pkg::R_SXXY)) state <= S_FETCH;
        end
        S_FETCH: state <= S_RDA;
        S_RDA: begin
          opa   <= rdata;
          state <= S_RDB;
        end
        S_RDB: begin
          opb <= rdata;
          priority case (ins.op)
            lscf_pkg::OP_MUL: begin
              acc   <= '0;
              mi    <= '0;
              mj    <= '0;
              mph   <= 1'b0;
              state <= S_MUL;
            end
            lscf_pkg::OP_DIV: begin
              acc   <= '0;
              rem   <= '0;
              cnt   <= CW'(W - 1);
              state <= S_DIV;
            end
            lscf_pkg::OP_SQRT: begin
              acc   <= '0;
              rem   <= '0;
              cnt   <= CW'(W / 2 - 1);
              state <= S_SQRT;
            end
            default: state <= S_ALU;
          endcase
        end
        S_ALU: begin
          priority case (ins.op)
            lscf_pkg::OP_CHKPOS: begin
              if ($signed(opa) <= $signed(W'(0))) begin
                st_r  <= lscf_pkg::ST_SING;
                state <= S_OUT;
              end else begin
                pc    <= pc + 1'b1;
                state <= S_FETCH;
              end
            end
            lscf_pkg::OP_CHKNN: begin
              if (opa[W-1]) begin
                st_r  <= lscf_pkg::ST_NEG;
                state <= S_OUT;
              end else begin
                pc    <= pc + 1'b1;
                state <= S_FETCH;
              end
            end
            lscf_pkg::OP_END: state <= S_OUT;
            default: begin
              acc   <= alu_res;
              state <= S_WB;
            end
          endcase
        end
        S_MUL: begin
          if (!mph) begin
            prod <= limb(opa, mi) * limb(opb, mj);
            mk   <= mi + mj;
            mph  <= 1'b1;
          end else begin
            acc <= acc + (W'(prod) << {mk, 5'b0});
            mph <= 1'b0;
            if (mk == LW'(lscf_pkg::LIMBS - 1)) begin
              if (mi == LW'(lscf_pkg::LIMBS - 1)) begin
                state <= S_WB;
              end else begin
                mi <= mi + 1'b1;
                mj <= '0;
              end
            end else begin
              mj <= mj + 1'b1;
            end
          end
        end
        S_DIV: begin
          rem <= rem_next;
          acc <= {acc[W-2:0], ge};
          opa <= opa << 1;
          if (cnt == '0) state <= S_WB;
          else cnt <= cnt - 1'b1;
        end
        S_SQRT: begin
          rem <= rem_next;
          acc <= {acc[W-2:0], ge};
          opa <= opa << 2;
          if (cnt == '0) state <= S_WB;
          else cnt <= cnt - 1'b1;
        end
        S_WB: begin
          if (ins.dst == lscf_pkg::R_CX)  cx_r  <= acc[31:0];
          if (ins.dst == lscf_pkg::R_CY)  cy_r  <= acc[31:0];
          if (ins.dst == lscf_pkg::R_RB)  rq_r  <= acc[31:0];
          if (ins.dst == lscf_pkg::R_ERR) err_r <= acc[63:0];
          pc    <= pc + 1'b1;
          state <= S_FETCH;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            o_cx     <= cx_r;
            o_cy     <= cy_r;
            o_rq     <= rq_r;
            o_err    <= err_r;
            o_cnt    <= snap.count;
            o_st     <= st_r;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {1'b0, o_st, o_cnt, o_err, o_rq, o_cy, o_cx};

  a_mul_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> ((5'(mi) + 5'(mj)) <= 5'(lscf_pkg::LIMBS - 1)))
    else $error("limb pair beyond product width");

  a_few_means_short: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_st == lscf_pkg::ST_FEW) |->
      (o_cnt < lscf_pkg::CNT_W'(lscf_pkg::MIN_POINTS)))
    else $error("too-few status on a full set");

  a_ok_means_enough: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_st == lscf_pkg::ST_OK) |->
      (o_cnt >= lscf_pkg::CNT_W'(lscf_pkg::MIN_POINTS)))
    else $error("fit reported on a short set");

endmodule

[hdl/least_squares_circle_fit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_squares_circle_fit: algebraic least-squares circle fit
// Points enter one beat per cycle while s_tready is high; the beat with tlast
// closes the set and its fit result leaves as one beat with center, radius,
// residual and status. The solver's pace is set by its one 32x32 limb
// multiplier, which builds each wide product limb by limb, and by the
// bit-serial divide and square root.
// The closing beat passes the multiply stages into the queue, then the fit.
// Up to four closed sets wait in the queue. Reset clears the sums and control state.
// ----------------------------------------------------------------------------
module least_squares_circle_fit #(
  parameter int MAX_POINTS  = lscf_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_BITS = lscf_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lscf_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [lscf_pkg::IN_W-1:0]  s_tdata,  // point_x, point_y
  input  logic                       s_tlast,  // last_point
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [lscf_pkg::OUT_W-1:0] m_tdata   // center_x, center_y, radius_out,
                                               // residual_sum, point_count, fit_status
);

  logic                        push, pop, q_valid;
  lscf_pkg::acc_set_t          push_data, q_data;
  logic [lscf_pkg::QCNT_W-1:0] q_count;

  lscf_front #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_POINTS(MAX_POINTS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  lscf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .count     (q_count)
  );

  lscf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
